>>> src/dsli_pkg.sv
// ----------------------------------------------------------------------------
// dsli_pkg
// Shared constants, command codes, control types and the logistic table for
// the dense sigmoid layer.
// ----------------------------------------------------------------------------
package dsli_pkg;

   localparam int DEF_MAX_INPUTS  = 64;
   localparam int DEF_MAX_HIDDEN  = 16;
   localparam int SIGMOID_ENTRIES = 256;
   localparam int SIG_BITS        = $clog2(SIGMOID_ENTRIES);

   localparam int CMD_W       = 2;
   localparam int HIDX_W      = 6;
   localparam int IIDX_W      = 8;
   localparam int VAL_W       = 16;
   localparam int PROB_W      = 16;
   localparam int ACC_W       = 40;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int FRAC_BITS   = 12;
   localparam int PRE_W       = ACC_W - FRAC_BITS + 1;
   localparam int COUNT_W     = 8;
   localparam int AI_W        = 9;
   localparam int AH_W        = 7;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BIAS   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_INPUTS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_HIDDEN = 1'd1;

   localparam logic [AI_W-1:0] ACTIVE_INPUTS_RST = 9'd64;
   localparam logic [AH_W-1:0] ACTIVE_HIDDEN_RST = 7'd16;

   localparam logic [63:0] ONE_Q32         = 64'h0000_0001_0000_0000;
   localparam logic [63:0] EXP_NEG_ONE_Q32 = 64'd1580030169;

   typedef struct packed {
      logic              wr_weight;
      logic              wr_bias;
      logic              load_sample;
      logic              mac_issue;
      logic              emit_issue;
      logic              emit_last;
      logic [HIDX_W-1:0] unit;
      logic [IIDX_W-1:0] col;
   } dp_cmd_type;

   typedef logic [SIGMOID_ENTRIES-1:0][PROB_W-1:0] sig_table_type;

   // restoring shift and subtract quotient, only used to build the table
   function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // round(65536 * sigmoid(bin midpoint)), exp(-a) from a q32 series
   function automatic logic [PROB_W-1:0] sig_entry(int k);
      longint      n;
      logic [63:0] mag;
      logic [63:0] aq;
      logic [63:0] ip;
      logic [63:0] fq;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] p;
      logic [63:0] i;
      n    = 2 * k + 1 - SIGMOID_ENTRIES;
      mag  = 64'(n < 0 ? -n : n);
      aq   = ((mag * 64'd8) << 32) / SIGMOID_ENTRIES;
      ip   = aq >> 32;
      fq   = aq & 64'h0000_0000_FFFF_FFFF;
      term = ONE_Q32;
      sum  = ONE_Q32;
      for (i = 64'd1; i <= 64'd20; i++) begin
         term = div_u64((term * fq) >> 32, i);
         sum  = sum + term;
      end
      e = div_u64(64'hFFFF_FFFF_FFFF_FFFF, sum);
      for (i = 64'd0; i < ip; i++) begin
         e = (e * EXP_NEG_ONE_Q32) >> 32;
      end
      den = ONE_Q32 + e;
      num = (n >= 0) ? (64'd1 << 48) : (e << 16);
      p   = div_u64(num + (den >> 1), den);
      return (p > 64'd65535) ? {PROB_W{1'b1}} : p[PROB_W-1:0];
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type t;
      for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
         t[k] = sig_entry(k);
      end
      return t;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

>>> src/dsli_ram.sv
// ----------------------------------------------------------------------------
// dsli_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dsli_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/dsli_ctrl.sv
// ----------------------------------------------------------------------------
// dsli_ctrl
// Controller: command decode, csr registers, element count and the per-unit
// sequencing of multiply-accumulate and emission.
// ----------------------------------------------------------------------------
module dsli_ctrl import dsli_pkg::*; #(
   parameter int MAX_INPUTS = DEF_MAX_INPUTS,
   parameter int MAX_HIDDEN = DEF_MAX_HIDDEN
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [CMD_W-1:0]       req_command,
   input  logic [HIDX_W-1:0]      req_hidden_index,
   input  logic [IIDX_W-1:0]      req_input_index,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output dp_cmd_type             dp_cmd
);

   localparam int HID_W = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
   localparam int IN_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

   typedef enum logic [2:0] {
      IDLE,
      MAC,
      DRAIN,
      EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic              busy_ff, busy_in;
   logic [AI_W-1:0]   active_inputs_ff, active_inputs_in;
   logic [AH_W-1:0]   active_hidden_ff, active_hidden_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [IIDX_W-1:0] col_ff, col_in;
   logic [HID_W-1:0]  h_ff, h_in;
   logic [HID_W-1:0]  nh_last_ff, nh_last_in;
   logic              run_end_ff, run_end_in;
   logic              drain_ff, drain_in;

   logic              accept;
   logic [AI_W-1:0]   eff_inputs;
   logic [AH_W-1:0]   eff_hidden;
   logic [COUNT_W-1:0] count_next;
   logic [IN_W-1:0]   col_sel;

   assign accept = start && !busy_ff;

   always_comb begin
      if (active_inputs_ff == '0) begin
         eff_inputs = AI_W'(1);
      end else if (active_inputs_ff > AI_W'(MAX_INPUTS)) begin
         eff_inputs = AI_W'(MAX_INPUTS);
      end else begin
         eff_inputs = active_inputs_ff;
      end
      if (active_hidden_ff == '0) begin
         eff_hidden = AH_W'(1);
      end else if (active_hidden_ff > AH_W'(MAX_HIDDEN)) begin
         eff_hidden = AH_W'(MAX_HIDDEN);
      end else begin
         eff_hidden = active_hidden_ff;
      end
      count_next = count_ff + COUNT_W'(1);
      if ({1'b0, count_ff} < AI_W'(MAX_INPUTS)) begin
         col_sel = count_ff[IN_W-1:0];
      end else begin
         col_sel = IN_W'(MAX_INPUTS - 1);
      end
   end

   always_comb begin
      state_in         = state_ff;
      active_inputs_in = active_inputs_ff;
      active_hidden_in = active_hidden_ff;
      count_in         = count_ff;
      col_in           = col_ff;
      h_in             = h_ff;
      nh_last_in       = nh_last_ff;
      run_end_in       = run_end_ff;
      drain_in         = drain_ff;

      dp_cmd             = '0;
      dp_cmd.unit        = HIDX_W'(h_ff);
      dp_cmd.col         = col_ff;

      if (csr_write_enable) begin
         case (csr_index)
            REG_ACTIVE_INPUTS: active_inputs_in = csr_data[AI_W-1:0];
            REG_ACTIVE_HIDDEN: active_hidden_in = csr_data[AH_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_WEIGHT: begin
                     dp_cmd.wr_weight = ({1'b0, req_hidden_index} < 7'(MAX_HIDDEN)) &&
                                        ({1'b0, req_input_index} < 9'(MAX_INPUTS));
                  end
                  CMD_BIAS: begin
                     dp_cmd.wr_bias = ({1'b0, req_hidden_index} < 7'(MAX_HIDDEN));
                  end
                  CMD_SAMPLE: begin
                     dp_cmd.load_sample = 1'b1;
                     col_in     = IIDX_W'(col_sel);
                     h_in       = '0;
                     nh_last_in = HID_W'(eff_hidden - AH_W'(1));
                     run_end_in = ({1'b0, count_next} >= eff_inputs) || (count_next == '0);
                     count_in   = ({1'b0, count_next} >= eff_inputs) ? '0 : count_next;
                     state_in   = MAC;
                  end
                  default: ;
               endcase
            end
         end
         MAC: begin
            dp_cmd.mac_issue = 1'b1;
            if (h_ff == nh_last_ff) begin
               drain_in = 1'b0;
               state_in = DRAIN;
            end else begin
               h_in = h_ff + HID_W'(1);
            end
         end
         DRAIN: begin
            if (drain_ff) begin
               h_in     = '0;
               state_in = run_end_ff ? EMIT : IDLE;
            end else begin
               drain_in = 1'b1;
            end
         end
         EMIT: begin
            dp_cmd.emit_issue = 1'b1;
            dp_cmd.emit_last  = (h_ff == nh_last_ff);
            if (h_ff == nh_last_ff) begin
               state_in = IDLE;
            end else begin
               h_in = h_ff + HID_W'(1);
            end
         end
         default: state_in = IDLE;
      endcase

      busy_in = (state_in != IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= IDLE;
         busy_ff          <= 1'b0;
         active_inputs_ff <= ACTIVE_INPUTS_RST;
         active_hidden_ff <= ACTIVE_HIDDEN_RST;
         count_ff         <= '0;
         h_ff             <= '0;
         drain_ff         <= 1'b0;
         run_end_ff       <= 1'b0;
      end else begin
         state_ff         <= state_in;
         busy_ff          <= busy_in;
         active_inputs_ff <= active_inputs_in;
         active_hidden_ff <= active_hidden_in;
         count_ff         <= count_in;
         h_ff             <= h_in;
         drain_ff         <= drain_in;
         run_end_ff       <= run_end_in;
      end
      col_ff     <= col_in;
      nh_last_ff <= nh_last_in;
   end

   assign busy = busy_ff;

endmodule

>>> src/dsli_datapath.sv
// ----------------------------------------------------------------------------
// dsli_datapath
// Datapath: weight RAM, bias and accumulator registers, shared saturating MAC
// and the clamp plus logistic table lookup for each result word.
// ----------------------------------------------------------------------------
module dsli_datapath import dsli_pkg::*; #(
   parameter int MAX_INPUTS = DEF_MAX_INPUTS,
   parameter int MAX_HIDDEN = DEF_MAX_HIDDEN
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               dp_cmd,
   input  logic [HIDX_W-1:0]        req_hidden_index,
   input  logic [IIDX_W-1:0]        req_input_index,
   input  logic signed [VAL_W-1:0]  req_value,
   output logic                     rsp_valid,
   output logic [HIDX_W-1:0]        rsp_unit_index,
   output logic [PROB_W-1:0]        rsp_probability,
   output logic                     rsp_last
);

   localparam int HID_W  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
   localparam int IN_W   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int WADDR_W = HID_W + IN_W;

   logic [VAL_W-1:0]  sample_ff, sample_in;
   logic [VAL_W-1:0]  bias_ff [MAX_HIDDEN];
   logic [VAL_W-1:0]  bias_in [MAX_HIDDEN];
   logic [ACC_W-1:0]  acc_ff  [MAX_HIDDEN];
   logic [ACC_W-1:0]  acc_in  [MAX_HIDDEN];

   logic              mac_v1_ff, mac_v1_in;
   logic [HID_W-1:0]  mac_h1_ff, mac_h1_in;
   logic              mac_v2_ff, mac_v2_in;
   logic [HID_W-1:0]  mac_h2_ff, mac_h2_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   logic              emit_v_ff, emit_v_in;
   logic [HID_W-1:0]  emit_h_ff, emit_h_in;
   logic              emit_last_ff, emit_last_in;
   logic [VAL_W-1:0]  pre_ff, pre_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [HIDX_W-1:0] rsp_unit_ff, rsp_unit_in;
   logic [PROB_W-1:0] rsp_prob_ff, rsp_prob_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [VAL_W-1:0]  weight_rd;
   logic [HID_W-1:0]  acc_addr;
   logic [ACC_W-1:0]  acc_rd;
   logic [ACC_W:0]    mac_sum;
   logic [ACC_W-1:0]  mac_sat;
   logic [PRE_W-1:0]  pre_wide;
   logic [VAL_W-1:0]  pre_ofs;
   logic [SIG_BITS-1:0] sig_idx;

   dsli_ram #(
      .WIDTH (VAL_W),
      .DEPTH (2 ** WADDR_W)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (dp_cmd.wr_weight),
      .wr_addr ({req_hidden_index[HID_W-1:0], req_input_index[IN_W-1:0]}),
      .wr_data (req_value),
      .rd_en   (dp_cmd.mac_issue),
      .rd_addr ({dp_cmd.unit[HID_W-1:0], dp_cmd.col[IN_W-1:0]}),
      .rd_data (weight_rd)
   );

   // one accumulator read port, shared by mac write-back and emission
   assign acc_addr = dp_cmd.emit_issue ? dp_cmd.unit[HID_W-1:0] : mac_h2_ff;
   assign acc_rd   = acc_ff[acc_addr];

   always_comb begin
      sample_in = dp_cmd.load_sample ? req_value : sample_ff;

      mac_v1_in = dp_cmd.mac_issue;
      mac_h1_in = dp_cmd.unit[HID_W-1:0];
      mac_v2_in = mac_v1_ff;
      mac_h2_in = mac_h1_ff;
      prod_in   = PROD_W'($signed(weight_rd) * $signed(sample_ff));

      mac_sum = {acc_rd[ACC_W-1], acc_rd} +
                {{(ACC_W + 1 - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      if (!mac_sum[ACC_W] && mac_sum[ACC_W-1]) begin
         mac_sat = {1'b0, {(ACC_W - 1){1'b1}}};
      end else if (mac_sum[ACC_W] && !mac_sum[ACC_W-1]) begin
         mac_sat = {1'b1, {(ACC_W - 1){1'b0}}};
      end else begin
         mac_sat = mac_sum[ACC_W-1:0];
      end

      bias_in = bias_ff;
      if (dp_cmd.wr_bias) begin
         bias_in[req_hidden_index[HID_W-1:0]] = req_value;
      end

      // the last word of a run clears every unit, emitted or not
      acc_in = acc_ff;
      if (dp_cmd.emit_issue && dp_cmd.emit_last) begin
         acc_in = '{default: '0};
      end else if (dp_cmd.emit_issue) begin
         acc_in[acc_addr] = '0;
      end else if (mac_v2_ff) begin
         acc_in[acc_addr] = mac_sat;
      end

      // floor shift of the accumulator plus bias, clamped to q4.12
      pre_wide = {acc_rd[ACC_W-1], acc_rd[ACC_W-1:FRAC_BITS]} +
                 {{(PRE_W - VAL_W){bias_ff[acc_addr][VAL_W-1]}}, bias_ff[acc_addr]};
      if (pre_wide[PRE_W-1:VAL_W-1] != {(PRE_W - VAL_W + 1){pre_wide[PRE_W-1]}}) begin
         pre_in = pre_wide[PRE_W-1] ? {1'b1, {(VAL_W - 1){1'b0}}}
                                    : {1'b0, {(VAL_W - 1){1'b1}}};
      end else begin
         pre_in = pre_wide[VAL_W-1:0];
      end
      emit_v_in    = dp_cmd.emit_issue;
      emit_h_in    = acc_addr;
      emit_last_in = dp_cmd.emit_last;

      pre_ofs      = {~pre_ff[VAL_W-1], pre_ff[VAL_W-2:0]};
      sig_idx      = pre_ofs[VAL_W-1 -: SIG_BITS];
      rsp_valid_in = emit_v_ff;
      rsp_unit_in  = HIDX_W'(emit_h_ff);
      rsp_prob_in  = SIG_TABLE[sig_idx];
      rsp_last_in  = emit_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_v1_ff    <= 1'b0;
         mac_v2_ff    <= 1'b0;
         emit_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_HIDDEN; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         mac_v1_ff    <= mac_v1_in;
         mac_v2_ff    <= mac_v2_in;
         emit_v_ff    <= emit_v_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
      sample_ff    <= sample_in;
      bias_ff      <= bias_in;
      mac_h1_ff    <= mac_h1_in;
      mac_h2_ff    <= mac_h2_in;
      prod_ff      <= prod_in;
      emit_h_ff    <= emit_h_in;
      emit_last_ff <= emit_last_in;
      pre_ff       <= pre_in;
      rsp_unit_ff  <= rsp_unit_in;
      rsp_prob_ff  <= rsp_prob_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_unit_index  = rsp_unit_ff;
   assign rsp_probability = rsp_prob_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

>>> src/dense_sigmoid_layer_inference.sv
// ----------------------------------------------------------------------------
// dense_sigmoid_layer_inference
// Hidden layer of a restricted Boltzmann machine in q4.12 with a logistic
// table on each accumulated hidden unit.
//
//   channel  ports                                   handshake
//   req      req_command/hidden_index/input_index/   start, busy
//            req_value
//   rsp      rsp_unit_index/probability/last         rsp_valid, one cycle
//   csr      csr_index, csr_data                     csr_write_enable
//
// A weight or bias word is taken without raising busy. A sample word runs one
// shared multiply-accumulate over the units, fed by the weight RAM read port,
// then a pipeline drain. The last word of a run adds emission of the active
// units, one result word per cycle, via the pre-activation and rsp registers.
// Reset is synchronous; accumulators and the element count clear at reset.
// Results are never held off by the receiver.
// ----------------------------------------------------------------------------
module dense_sigmoid_layer_inference import dsli_pkg::*; #(
   parameter int MAX_INPUTS = DEF_MAX_INPUTS,
   parameter int MAX_HIDDEN = DEF_MAX_HIDDEN
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [CMD_W-1:0]        req_command,
   input  logic [HIDX_W-1:0]       req_hidden_index,
   input  logic [IIDX_W-1:0]       req_input_index,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   output logic [HIDX_W-1:0]       rsp_unit_index,
   output logic [PROB_W-1:0]       rsp_probability,
   output logic                    rsp_last,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   dp_cmd_type dp_cmd;

   dsli_ctrl #(
      .MAX_INPUTS (MAX_INPUTS),
      .MAX_HIDDEN (MAX_HIDDEN)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_hidden_index (req_hidden_index),
      .req_input_index  (req_input_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .dp_cmd           (dp_cmd)
   );

   dsli_datapath #(
      .MAX_INPUTS (MAX_INPUTS),
      .MAX_HIDDEN (MAX_HIDDEN)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .req_hidden_index (req_hidden_index),
      .req_input_index  (req_input_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_unit_index   (rsp_unit_index),
      .rsp_probability  (rsp_probability),
      .rsp_last         (rsp_last)
   );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dense sigmoid layer. Weights are loaded first
// for a narrow band of inputs on every unit and for every input of unit 0,
// together with all biases; register settings keep each read inside that
// band. A directed stimulus table then covers the clamp extremes, the ignored
// out of range writes, the unused command and a register change in the middle
// of a sample. Random phases follow, each with its own register setting.
// Results are checked against a local layer predictor or a row's own value.
// ----------------------------------------------------------------------------
module testbench;
   import dsli_pkg::*;

   localparam int MAX_I = DEF_MAX_INPUTS;
   localparam int MAX_H = DEF_MAX_HIDDEN;
   localparam int LUT_SIZE = SIGMOID_ENTRIES;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RAND_ITEMS = 120;
   localparam int NARROW_COLS = 8;
   localparam int WIDE_UNITS = 1;
   localparam int IDLE_PAUSE = 2 * MAX_H + 8;
   localparam longint CYCLE_LIMIT = 500000;
   localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;
   localparam longint ACC_HI = (longint'(1) <<< 39) - 1;
   localparam longint ACC_LO = -(longint'(1) <<< 39);
   localparam longint PRE_HI = 32767;
   localparam longint PRE_LO = -32768;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [HIDX_W-1:0]       hid;
      logic [IIDX_W-1:0]       inp;
      logic signed [VAL_W-1:0] val;
   } req_word_type;

   typedef struct packed {
      logic [HIDX_W-1:0] unit;
      logic [PROB_W-1:0] prob;
      logic              last;
   } rsp_word_type;

   typedef struct {
      row_kind_type           kind;
      req_word_type           w;
      bit                     typed;
      logic [PROB_W-1:0]      prob;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
   } dir_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [CMD_W-1:0]        req_command = '0;
   logic [HIDX_W-1:0]       req_hidden_index = '0;
   logic [IIDX_W-1:0]       req_input_index = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic [HIDX_W-1:0]       rsp_unit_index;
   logic [PROB_W-1:0]       rsp_probability;
   logic                    rsp_last;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   // layer predictor state
   logic [PROB_W-1:0]       logistic_lut [LUT_SIZE];
   logic signed [VAL_W-1:0] wt_mem [MAX_H][MAX_I];
   logic signed [VAL_W-1:0] bias_mem [MAX_H];
   longint                  acc_mem [MAX_H];
   logic [COUNT_W-1:0]      elem_cnt = '0;
   logic [AI_W-1:0]         cfg_inputs = 9'd64;
   logic [AH_W-1:0]         cfg_hidden = 7'd16;

   rsp_word_type prob_q [$];
   rsp_word_type head;
   dir_row_type  dir_rows [$];
   int           err_count = 0;
   int           result_count = 0;
   int           rand_sent = 0;
   int           burst_left = 0;
   longint       cycle_count = 0;

   dense_sigmoid_layer_inference dut (.*);

   always #5 clock = ~clock;

   function automatic logic [PROB_W-1:0] logistic_bin(int k);
      int          n;
      logic [63:0] a;
      logic [63:0] ip;
      logic [63:0] fq;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] p;
      n    = 2 * k + 1 - LUT_SIZE;
      a    = ((64'(n < 0 ? -n : n) * 64'd8) << 32) / 64'(LUT_SIZE);
      ip   = a >> 32;
      fq   = {32'd0, a[31:0]};
      term = 64'd1 << 32;
      sum  = term;
      for (int i = 1; i <= 20; i++) begin
         term = ((term * fq) >> 32) / 64'(i);
         sum  = sum + term;
      end
      e = {64{1'b1}} / sum;
      for (int j = 0; j < int'(ip); j++) begin
         e = (e * EXP_M1_Q32) >> 32;
      end
      den = (64'd1 << 32) + e;
      num = (n >= 0) ? (64'd1 << 48) : (e << 16);
      p   = (num + (den >> 1)) / den;
      return (p > 64'd65535) ? {PROB_W{1'b1}} : p[PROB_W-1:0];
   endfunction

   function automatic int eff_inputs();
      if (cfg_inputs < 1) return 1;
      return (cfg_inputs > MAX_I) ? MAX_I : int'(cfg_inputs);
   endfunction

   function automatic int eff_hidden();
      if (cfg_hidden < 1) return 1;
      return (cfg_hidden > MAX_H) ? MAX_H : int'(cfg_hidden);
   endfunction

   function automatic void step_layer(input req_word_type w, ref rsp_word_type res[$]);
      int           nh;
      int           col;
      int           idx;
      longint       s;
      longint       pre;
      rsp_word_type r;
      nh = eff_hidden();
      case (w.cmd)
         CMD_WEIGHT: begin
            if (w.hid < MAX_H && w.inp < MAX_I) wt_mem[w.hid][w.inp] = w.val;
         end
         CMD_BIAS: begin
            if (w.hid < MAX_H) bias_mem[w.hid] = w.val;
         end
         CMD_SAMPLE: begin
            col = (elem_cnt < MAX_I) ? int'(elem_cnt) : MAX_I - 1;
            for (int h = 0; h < nh; h++) begin
               s = acc_mem[h] + longint'(wt_mem[h][col]) * longint'($signed(w.val));
               if (s > ACC_HI) s = ACC_HI;
               if (s < ACC_LO) s = ACC_LO;
               acc_mem[h] = s;
            end
            elem_cnt = elem_cnt + 1'b1;
            if (elem_cnt >= eff_inputs() || elem_cnt == 0) begin
               for (int h = 0; h < nh; h++) begin
                  pre = (acc_mem[h] >>> FRAC_BITS) + longint'(bias_mem[h]);
                  if (pre > PRE_HI) pre = PRE_HI;
                  if (pre < PRE_LO) pre = PRE_LO;
                  idx = int'(((pre - PRE_LO) * LUT_SIZE) >>> 16);
                  if (idx >= LUT_SIZE) idx = LUT_SIZE - 1;
                  r.unit = HIDX_W'(h);
                  r.prob = logistic_lut[idx];
                  r.last = (h == nh - 1);
                  res.insert(res.size(), r);
               end
               foreach (acc_mem[h]) acc_mem[h] = 0;
               elem_cnt = '0;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic signed [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3: return VAL_W'($urandom);
         default: return VAL_W'(int'($urandom_range(0, 2047)) - 1024);
      endcase
   endfunction

   function automatic dir_row_type word_row(logic [CMD_W-1:0] cmd, int hid, int inp,
                                            logic signed [VAL_W-1:0] val);
      dir_row_type row;
      row.kind    = ROW_WORD;
      row.w.cmd   = cmd;
      row.w.hid   = HIDX_W'(hid);
      row.w.inp   = IIDX_W'(inp);
      row.w.val   = val;
      row.typed   = 1'b0;
      row.prob    = '0;
      row.csr_idx = '0;
      row.csr_val = '0;
      return row;
   endfunction

   function automatic dir_row_type typed_row(logic signed [VAL_W-1:0] val,
                                             logic [PROB_W-1:0] prob);
      dir_row_type row;
      row       = word_row(CMD_SAMPLE, 0, 0, val);
      row.typed = 1'b1;
      row.prob  = prob;
      return row;
   endfunction

   function automatic dir_row_type csr_row(logic [CSR_INDEX_W-1:0] idx, int val);
      dir_row_type row;
      row         = word_row(CMD_UNUSED, 0, 0, '0);
      row.kind    = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = CSR_DATA_W'(val);
      return row;
   endfunction

   function automatic void queue_row(input dir_row_type row);
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("result %0d %s: got %0d, expected %0d", result_count, what, got, want);
      err_count++;
   endtask

   task automatic send_word(input req_word_type w, input bit typed,
                            input logic [PROB_W-1:0] tprob);
      int           gap;
      rsp_word_type r;
      rsp_word_type pred_q [$];
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_command      <= w.cmd;
      req_hidden_index <= w.hid;
      req_input_index  <= w.inp;
      req_value        <= w.val;
      start            <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      step_layer(w, pred_q);
      if (typed) begin
         r.unit = '0;
         r.prob = tprob;
         r.last = 1'b1;
         prob_q.insert(prob_q.size(), r);
      end else begin
         foreach (pred_q[i]) prob_q.insert(prob_q.size(), pred_q[i]);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      burst_left = 0;
      while (prob_q.size() != 0) @(posedge clock);
      repeat (IDLE_PAUSE) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      if (idx == REG_ACTIVE_INPUTS) cfg_inputs = AI_W'(data);
      else cfg_hidden = AH_W'(data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase();
      int                    n;
      int                    kind;
      logic [CSR_DATA_W-1:0] ai;
      logic [CSR_DATA_W-1:0] ah;
      req_word_type          w;
      case ($urandom_range(0, 15))
         0: ai = 0;
         1: ai = 1;
         2: ai = 511;
         3: ai = 256;
         4: ai = 64;
         5: ai = CSR_DATA_W'($urandom_range(65, 510));
         default: ai = CSR_DATA_W'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 9))
         0: ah = 0;
         1: ah = 1;
         2: ah = 127;
         3: ah = 64;
         4: ah = 16;
         5: ah = CSR_DATA_W'($urandom_range(17, 126));
         default: ah = CSR_DATA_W'($urandom_range(2, 15));
      endcase
      wait_idle();
      // wide columns are loaded only for the first units
      if (ai > NARROW_COLS || elem_cnt >= NARROW_COLS)
         ah = CSR_DATA_W'($urandom_range(0, WIDE_UNITS));
      write_csr(REG_ACTIVE_INPUTS, ai);
      write_csr(REG_ACTIVE_HIDDEN, ah);
      n = (ai >= MAX_I) ? $urandom_range(80, 110) : $urandom_range(20, 50);
      for (int i = 0; i < n; i++) begin
         kind  = $urandom_range(0, 99);
         w.hid = HIDX_W'($urandom);
         w.inp = IIDX_W'($urandom);
         w.val = rand_value();
         if (kind < 70) begin
            w.cmd = CMD_SAMPLE;
            rand_sent++;
         end else if (kind < 82) begin
            w.cmd = CMD_WEIGHT;
            w.hid = HIDX_W'($urandom_range(0, MAX_H - 1));
            w.inp = IIDX_W'($urandom_range(0, MAX_I - 1));
            rand_sent++;
         end else if (kind < 90) begin
            w.cmd = CMD_BIAS;
            w.hid = HIDX_W'($urandom_range(0, MAX_H - 1));
            rand_sent++;
         end else if (kind < 95) begin
            if ($urandom_range(0, 1)) begin
               w.cmd = CMD_BIAS;
               w.hid = HIDX_W'($urandom_range(MAX_H, (1 << HIDX_W) - 1));
            end else if ($urandom_range(0, 1)) begin
               w.cmd = CMD_WEIGHT;
               w.hid = HIDX_W'($urandom_range(MAX_H, (1 << HIDX_W) - 1));
            end else begin
               w.cmd = CMD_WEIGHT;
               w.hid = HIDX_W'($urandom_range(0, MAX_H - 1));
               w.inp = IIDX_W'($urandom_range(MAX_I, (1 << IIDX_W) - 1));
            end
         end else begin
            w.cmd = CMD_UNUSED;
         end
         send_word(w, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (prob_q.size() == 0) begin
            report_mismatch("word with none expected, unit_index", rsp_unit_index, -1);
         end else begin
            head = prob_q.pop_front();
            if (rsp_unit_index !== head.unit)
               report_mismatch("unit_index", rsp_unit_index, head.unit);
            if (rsp_probability !== head.prob)
               report_mismatch("probability", rsp_probability, head.prob);
            if (rsp_last !== head.last)
               report_mismatch("last", rsp_last, head.last);
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d words outstanding", prob_q.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      dir_row_type  row;
      req_word_type w;
      for (int k = 0; k < LUT_SIZE; k++) logistic_lut[k] = logistic_bin(k);
      foreach (acc_mem[h]) acc_mem[h] = 0;

      // single unit, single element runs: clamp extremes and a pre-activation just below zero
      queue_row(csr_row(REG_ACTIVE_INPUTS, 0));
      queue_row(csr_row(REG_ACTIVE_HIDDEN, 0));
      queue_row(word_row(CMD_BIAS, 0, 0, 16'sh7FFF));
      queue_row(typed_row(16'sh0000, 16'd65513));
      queue_row(word_row(CMD_BIAS, 0, 0, 16'sh8000));
      queue_row(typed_row(16'sh0000, 16'd23));
      queue_row(word_row(CMD_BIAS, 0, 0, 16'sh0000));
      queue_row(word_row(CMD_WEIGHT, 0, 0, 16'sh7FFF));
      queue_row(typed_row(16'sh8000, 16'd23));
      queue_row(typed_row(16'sh7FFF, 16'd65513));
      queue_row(word_row(CMD_WEIGHT, 0, 0, 16'sh0000));
      queue_row(word_row(CMD_BIAS, 0, 0, -16'sd1));
      queue_row(typed_row(16'shAAAA, 16'd32256));
      queue_row(word_row(CMD_BIAS, 0, 0, 16'sh0000));
      // out of range writes must not alias onto unit 0
      queue_row(word_row(CMD_WEIGHT, MAX_H, 0, 16'sh5555));
      queue_row(word_row(CMD_WEIGHT, 0, MAX_I, -16'sd1));
      queue_row(word_row(CMD_WEIGHT, 63, 255, 16'sh7FFF));
      queue_row(word_row(CMD_BIAS, MAX_H, 0, 16'sh4000));
      queue_row(word_row(CMD_BIAS, 63, 0, 16'sh8000));
      queue_row(word_row(CMD_UNUSED, 63, 255, -16'sd1));
      queue_row(typed_row(16'sh5555, 16'd33280));
      // register change in the middle of a sample
      queue_row(csr_row(REG_ACTIVE_INPUTS, 3));
      queue_row(csr_row(REG_ACTIVE_HIDDEN, 127));
      queue_row(word_row(CMD_SAMPLE, 0, 0, 16'sh1234));
      queue_row(word_row(CMD_SAMPLE, 63, 255, -16'sd3000));
      queue_row(csr_row(REG_ACTIVE_HIDDEN, 2));
      queue_row(csr_row(REG_ACTIVE_INPUTS, 2));
      queue_row(word_row(CMD_SAMPLE, 21, 170, 16'sh0800));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int h = 0; h < MAX_H; h++) begin
         for (int i = 0; i < MAX_I; i++) begin
            if (h < WIDE_UNITS || i < NARROW_COLS) begin
               w.cmd = CMD_WEIGHT;
               w.hid = HIDX_W'(h);
               w.inp = IIDX_W'(i);
               w.val = rand_value();
               send_word(w, 1'b0, '0);
            end
         end
         w.cmd = CMD_BIAS;
         w.hid = HIDX_W'(h);
         w.inp = IIDX_W'($urandom);
         w.val = rand_value();
         send_word(w, 1'b0, '0);
      end

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            write_csr(row.csr_idx, row.csr_val);
         end else begin
            send_word(row.w, row.typed, row.prob);
         end
      end

      while (rand_sent < RAND_ITEMS) random_phase();

      wait_idle();
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/dsli_pkg.sv
src/dsli_ram.sv
src/dsli_ctrl.sv
src/dsli_datapath.sv
src/dense_sigmoid_layer_inference.sv
bench/testbench.sv
